[design/dxs_pkg.sv]
`default_nettype none
package dxs_pkg;

  localparam int FEET_W = 12;
  localparam int INCH_W = 12;
  localparam int KEY_W  = 20;

  // sixteenths of an inch in one foot
  localparam int FOOT_SIXTEENTHS = 192;

  // front queue depth, power of two
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [FEET_W-1:0] feet;
    logic [INCH_W-1:0] inches;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    entry_t span;
    logic   final_item;
  } item_t;

  typedef enum logic [1:0] {
    B_LOAD,
    B_HOLD,
    B_SCAN,
    B_EMIT
  } back_state_t;

  // feet*192 + inches, as two shifts and adds
  function automatic logic [KEY_W-1:0] dist_key(input entry_t e);
    return (KEY_W'(e.feet) << 7) + (KEY_W'(e.feet) << 6) + KEY_W'(e.inches);
  endfunction

endpackage
`default_nettype wire

[design/dxs_ram.sv]
`default_nettype none
module dxs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/dxs_front.sv]
`default_nettype none
module dxs_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [dxs_pkg::FEET_W-1:0] in_dist_feet,
  input  wire logic [dxs_pkg::INCH_W-1:0] in_dist_inches,
  input  wire logic                   in_final_item,
  output logic                        q_valid,
  output dxs_pkg::item_t              q_item,
  input  wire logic                   q_pop
);

  localparam int PW = $clog2(dxs_pkg::QDEPTH);
  localparam int CW = $clog2(dxs_pkg::QDEPTH + 1);

  dxs_pkg::item_t slot_r [dxs_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          push;
  dxs_pkg::item_t in_item;

  assign in_item.span.feet   = in_dist_feet;
  assign in_item.span.inches = in_dist_inches;
  assign in_item.final_item  = in_final_item;

  assign in_ready = (fill_r != CW'(dxs_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill_r != '0);
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !q_pop) begin
      fill_nxt = fill_r + CW'(1);
    end else if (!push && q_pop) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

endmodule
`default_nettype wire

[design/dxs_back.sv]
`default_nettype none
module dxs_back #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_valid,
  input  wire dxs_pkg::item_t         q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [dxs_pkg::FEET_W-1:0]  out_feet,
  output logic [dxs_pkg::INCH_W-1:0]  out_inches,
  output logic                        out_run_end,
  output logic                        out_overflow_dropped
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  dxs_pkg::back_state_t state_r, state_nxt;

  logic [CNT_W-1:0]          cnt_r;
  logic                      drop_r;
  logic [IDX_W-1:0]          i_r;
  logic [IDX_W-1:0]          j_r;
  dxs_pkg::entry_t           cur_r;
  logic [dxs_pkg::KEY_W-1:0] key_i_r;
  dxs_pkg::entry_t           first_r;

  logic                      out_valid_r;
  dxs_pkg::entry_t           out_r;
  logic                      out_end_r;
  logic                      out_drop_r;

  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [dxs_pkg::ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]            ram_raddr;
  logic [dxs_pkg::ENTRY_W-1:0] ram_rdata;

  dxs_pkg::entry_t           rd_entry;
  logic [dxs_pkg::KEY_W-1:0] rd_key;
  dxs_pkg::entry_t           hold_entry;
  logic [dxs_pkg::KEY_W-1:0] hold_key;
  logic                      store;
  logic                      swap;
  logic                      emit;
  logic                      out_free;
  logic                      i_last;
  logic                      j_last;

  dxs_ram #(
    .WIDTH (dxs_pkg::ENTRY_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = dxs_pkg::entry_t'(ram_rdata);
  assign rd_key   = dxs_pkg::dist_key(rd_entry);
  // entry 0 may be written on the very edge that reads it; take it from the copy
  assign hold_entry = (i_r == '0) ? first_r : rd_entry;
  assign hold_key   = dxs_pkg::dist_key(hold_entry);
  assign out_free = !out_valid_r || out_ready;
  assign i_last   = (CNT_W'(i_r) + CNT_W'(1)) == cnt_r;
  assign j_last   = (CNT_W'(j_r) + CNT_W'(1)) == cnt_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dxs_pkg::B_LOAD: begin
        if (q_valid && q_item.final_item) begin
          state_nxt = dxs_pkg::B_HOLD;
        end
      end
      dxs_pkg::B_HOLD: begin
        state_nxt = i_last ? dxs_pkg::B_EMIT : dxs_pkg::B_SCAN;
      end
      dxs_pkg::B_SCAN: begin
        if (j_last) begin
          state_nxt = dxs_pkg::B_EMIT;
        end
      end
      dxs_pkg::B_EMIT: begin
        if (out_free) begin
          state_nxt = i_last ? dxs_pkg::B_LOAD : dxs_pkg::B_HOLD;
        end
      end
      default: state_nxt = dxs_pkg::B_LOAD;
    endcase
  end

  // strobes and memory controls
  always_comb begin
    q_pop     = 1'b0;
    store     = 1'b0;
    swap      = 1'b0;
    emit      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = j_r;
    ram_wdata = cur_r;
    ram_raddr = i_r + IDX_W'(1);
    case (state_r)
      dxs_pkg::B_LOAD: begin
        q_pop     = q_valid;
        store     = q_valid && (cnt_r < CNT_W'(MAX_ITEMS));
        ram_we    = store;
        ram_waddr = cnt_r[IDX_W-1:0];
        ram_wdata = q_item.span;
        ram_raddr = '0;
      end
      dxs_pkg::B_HOLD: begin
        ram_raddr = i_r + IDX_W'(1);
      end
      dxs_pkg::B_SCAN: begin
        swap      = key_i_r < rd_key;
        ram_we    = swap;
        ram_raddr = j_r + IDX_W'(1);
      end
      dxs_pkg::B_EMIT: begin
        emit      = out_free;
        ram_raddr = i_r + IDX_W'(1);
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dxs_pkg::B_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        if (store) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end else begin
          drop_r <= 1'b1;
        end
      end
      if (emit && i_last) begin
        cnt_r  <= '0;
        drop_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store && (cnt_r == '0)) begin
      first_r <= q_item.span;
    end
    if (q_pop && q_item.final_item) begin
      i_r <= '0;
    end
    if (state_r == dxs_pkg::B_HOLD) begin
      cur_r   <= hold_entry;
      key_i_r <= hold_key;
      j_r     <= i_r + IDX_W'(1);
    end
    if (state_r == dxs_pkg::B_SCAN) begin
      j_r <= j_r + IDX_W'(1);
      if (swap) begin
        cur_r   <= rd_entry;
        key_i_r <= rd_key;
      end
    end
    if (emit) begin
      out_r      <= cur_r;
      out_end_r  <= i_last;
      out_drop_r <= drop_r;
      i_r        <= i_r + IDX_W'(1);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_feet             = out_r.feet;
  assign out_inches           = out_r.inches;
  assign out_run_end          = out_end_r;
  assign out_overflow_dropped = out_drop_r;

endmodule
`default_nettype wire

[design/distance_exchange_sorter.sv]
// Flow: an item is queued in the front and then stored by the back end; a run of N items
// is then sorted and emitted, the exchange-sort compare loop over the store (one read
// port, one write port) being the limit.
// Throughput: one transaction per cycle while loading; no new item is stored until the run is emitted.
// Reset (rst_n, synchronous, active low) empties the queue, the count and the
// overflow flag and drops any pending result; the store itself is not cleared.
`default_nettype none
module distance_exchange_sorter #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [dxs_pkg::FEET_W-1:0] in_dist_feet,
  input  wire logic [dxs_pkg::INCH_W-1:0] in_dist_inches,
  input  wire logic                       in_final_item,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [dxs_pkg::FEET_W-1:0]      out_feet,
  output logic [dxs_pkg::INCH_W-1:0]      out_inches,
  output logic                            out_run_end,
  output logic                            out_overflow_dropped
);

  // Front: two-entry queue of incoming transactions, so the input side can still
  // accept up to two of them while the back end is busy sorting.
  logic           q_valid;
  dxs_pkg::item_t q_item;
  logic           q_pop;

  dxs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_dist_feet   (in_dist_feet),
    .in_dist_inches (in_dist_inches),
    .in_final_item  (in_final_item),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  // Back: stores items, then on the final one runs the exchange sort.
  // Entry i is held in a register while entries i+1..N-1 stream past it;
  // the winner of each swap stays in the register and the loser is written
  // back. Once the inner pass ends, entry i is final and goes straight to
  // the output register, so no separate read-out pass is needed.
  dxs_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_item               (q_item),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_feet             (out_feet),
    .out_inches           (out_inches),
    .out_run_end          (out_run_end),
    .out_overflow_dropped (out_overflow_dropped)
  );

endmodule
`default_nettype wire

[dv/sorted_run_checker.sv]
`timescale 1ns / 1ps
module sorted_run_checker #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_ready,
  input  wire logic [dxs_pkg::FEET_W-1:0] in_dist_feet,
  input  wire logic [dxs_pkg::INCH_W-1:0] in_dist_inches,
  input  wire logic                       in_final_item,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire logic [dxs_pkg::FEET_W-1:0] out_feet,
  input  wire logic [dxs_pkg::INCH_W-1:0] out_inches,
  input  wire logic                       out_run_end,
  input  wire logic                       out_overflow_dropped,
  output int                              fail_count,
  output int                              pending_results,
  output int                              results_seen,
  output int                              runs_done,
  output int                              runs_dropped
);

  localparam int SHOWN_MAX = 100;

  typedef struct {
    dxs_pkg::entry_t span;
    logic            run_end;
    logic            dropped;
  } sorted_result_t;

  dxs_pkg::entry_t held[MAX_ITEMS];
  int              held_count;
  logic            store_overflowed;
  sorted_result_t  sorted_q[$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
    results_seen    = 0;
    runs_done       = 0;
    runs_dropped    = 0;
    held_count      = 0;
    store_overflowed = 1'b0;
  end

  function automatic logic [dxs_pkg::KEY_W-1:0] dist_sixteenths(dxs_pkg::entry_t e);
    return dxs_pkg::KEY_W'(e.feet) * dxs_pkg::KEY_W'(dxs_pkg::FOOT_SIXTEENTHS)
           + dxs_pkg::KEY_W'(e.inches);
  endfunction

  task automatic note_mismatch(string what, int want, int got);
    fail_count++;
    if (fail_count <= SHOWN_MAX) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end else if (fail_count == SHOWN_MAX + 1) begin
      $display("%0t: further mismatches not shown", $time);
    end
  endtask

  // store the item, and on the last one of a set sort and queue the run
  task automatic take_item(dxs_pkg::entry_t d, logic fin);
    dxs_pkg::entry_t tmp;
    sorted_result_t  r;
    if (held_count < MAX_ITEMS) begin
      held[held_count] = d;
      held_count++;
    end else begin
      store_overflowed = 1'b1;
    end
    if (fin) begin
      for (int i = 0; i < held_count; i++) begin
        for (int j = i + 1; j < held_count; j++) begin
          if (dist_sixteenths(held[i]) < dist_sixteenths(held[j])) begin
            tmp     = held[i];
            held[i] = held[j];
            held[j] = tmp;
          end
        end
      end
      for (int k = 0; k < held_count; k++) begin
        r.span    = held[k];
        r.run_end = (k == held_count - 1);
        r.dropped = store_overflowed;
        sorted_q.push_back(r);
      end
      runs_done++;
      if (store_overflowed) runs_dropped++;
      held_count       = 0;
      store_overflowed = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    sorted_result_t  want;
    dxs_pkg::entry_t d;
    if (!rst_n) begin
      held_count       = 0;
      store_overflowed = 1'b0;
      sorted_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (sorted_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got feet %0d inches %0d",
                   $time, out_feet, out_inches);
        end else begin
          want = sorted_q.pop_front();
          if (out_feet !== want.span.feet)
            note_mismatch("out_feet", int'(want.span.feet), int'(out_feet));
          if (out_inches !== want.span.inches)
            note_mismatch("out_inches", int'(want.span.inches), int'(out_inches));
          if (out_run_end !== want.run_end)
            note_mismatch("out_run_end", int'(want.run_end), int'(out_run_end));
          if (out_overflow_dropped !== want.dropped)
            note_mismatch("out_overflow_dropped", int'(want.dropped),
                          int'(out_overflow_dropped));
        end
      end
      if (in_valid && in_ready) begin
        d.feet   = in_dist_feet;
        d.inches = in_dist_inches;
        take_item(d, in_final_item);
      end
    end
    pending_results = sorted_q.size();
  end

endmodule

[dv/distance_exchange_sorter_test.sv]
`timescale 1ns / 1ps
module distance_exchange_sorter_test;

  localparam int STORE_DEPTH  = 64;
  localparam int ITEM_TARGET  = 450;
  // worst case is far below this: at most 519 items, each with a long gap, a long
  // output stall and its share of a full 64-entry sort
  localparam int CYCLE_LIMIT  = 600000;
  // idle cycles after the last result, to catch anything extra
  localparam int DRAIN_CYCLES = 200;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [dxs_pkg::FEET_W-1:0] in_dist_feet;
  logic [dxs_pkg::INCH_W-1:0] in_dist_inches;
  logic                       in_final_item;
  logic                       out_valid;
  logic                       out_ready;
  logic [dxs_pkg::FEET_W-1:0] out_feet;
  logic [dxs_pkg::INCH_W-1:0] out_inches;
  logic                       out_run_end;
  logic                       out_overflow_dropped;

  int fail_count;
  int pending_results;
  int results_seen;
  int runs_done;
  int runs_dropped;

  int items_sent = 0;
  int cycles     = 0;
  bit no_gaps    = 1'b0;

  distance_exchange_sorter #(
    .MAX_ITEMS(STORE_DEPTH)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_dist_feet        (in_dist_feet),
    .in_dist_inches      (in_dist_inches),
    .in_final_item       (in_final_item),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_feet            (out_feet),
    .out_inches          (out_inches),
    .out_run_end         (out_run_end),
    .out_overflow_dropped(out_overflow_dropped)
  );

  // prediction and comparison live in the watcher; it hands back counts only
  sorted_run_checker #(
    .MAX_ITEMS(STORE_DEPTH)
  ) run_watch (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_dist_feet        (in_dist_feet),
    .in_dist_inches      (in_dist_inches),
    .in_final_item       (in_final_item),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_feet            (out_feet),
    .out_inches          (out_inches),
    .out_run_end         (out_run_end),
    .out_overflow_dropped(out_overflow_dropped),
    .fail_count          (fail_count),
    .pending_results     (pending_results),
    .results_seen        (results_seen),
    .runs_done           (runs_done),
    .runs_dropped        (runs_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results);
      $display("tb: failure");
      $finish;
    end
  end

  // gap before the next transaction: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // 0: anything; 1: a narrow band so equal keys turn up; 2: the extremes
  function automatic dxs_pkg::entry_t pick_dist(int mode);
    dxs_pkg::entry_t d;
    case (mode)
      1: begin
        d.feet   = dxs_pkg::FEET_W'($urandom_range(0, 3));
        d.inches = dxs_pkg::INCH_W'($urandom_range(0, 400));
      end
      2: begin
        d.feet   = $urandom_range(0, 1) ? dxs_pkg::FEET_W'($urandom_range(4094, 4095))
                                        : dxs_pkg::FEET_W'($urandom_range(0, 1));
        d.inches = $urandom_range(0, 1) ? dxs_pkg::INCH_W'($urandom_range(4094, 4095))
                                        : dxs_pkg::INCH_W'($urandom_range(0, 1));
      end
      default: begin
        d.feet   = dxs_pkg::FEET_W'($urandom_range(0, 4095));
        d.inches = dxs_pkg::INCH_W'($urandom_range(0, 4095));
      end
    endcase
    return d;
  endfunction

  // valid is only dropped when a gap is wanted, so back-to-back
  // transactions keep it high across the edge
  task automatic send_item(logic [dxs_pkg::FEET_W-1:0] f, logic [dxs_pkg::INCH_W-1:0] i,
                           logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_dist_feet   <= f;
    in_dist_inches <= i;
    in_final_item  <= fin;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_set(int n, int mode);
    dxs_pkg::entry_t d;
    for (int k = 0; k < n; k++) begin
      d = pick_dist(mode);
      send_item(d.feet, d.inches, k == n - 1);
    end
  endtask

  // sender holds off until every queued result has drained
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results == 0);
  endtask

  // result side: bursts of ready with short stalls, the odd long stall,
  // and now and then a long stretch with no back-pressure at all
  initial begin
    int burst;
    int stall;
    out_ready = 1'b0;
    forever begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                          : $urandom_range(1, 12);
      stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                          : $urandom_range(1, 3);
      repeat (burst) begin
        @(negedge clk);
        out_ready <= 1'b1;
      end
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
    end
  end

  initial begin
    int roll;
    int set_len;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_dist_feet   = '0;
    in_dist_inches = '0;
    in_final_item  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single-item runs at the bottom and top of the key range
    send_item(12'd0, 12'd0, 1'b1);
    send_item(12'd4095, 12'd4095, 1'b1);

    // equal keys written different ways: 1 ft = 192/16 in, 21 ft 63 = 0 ft 4095
    send_item(12'd0, 12'd192, 1'b0);
    send_item(12'd1, 12'd0, 1'b0);
    send_item(12'd3, 12'd7, 1'b0);
    send_item(12'd21, 12'd63, 1'b0);
    send_item(12'd0, 12'd4095, 1'b0);
    send_item(12'd1, 12'd0, 1'b1);

    // ascending input forces swaps; alternating patterns toggle every bit
    send_item(12'd0, 12'd1, 1'b0);
    send_item(12'd0, 12'd2, 1'b0);
    send_item(12'hAAA, 12'h555, 1'b0);
    send_item(12'h555, 12'hAAA, 1'b0);
    send_item(12'hFFF, 12'h000, 1'b1);

    hold_until_drained();

    // over capacity: the last two, the final one among them, are dropped
    send_set(STORE_DEPTH + 2, 0);
    // exactly full: final item is stored, nothing dropped
    send_set(STORE_DEPTH, 1);

    hold_until_drained();

    // random sets: mostly short, some middling, a few near, at or past capacity
    while (items_sent < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      roll    = $urandom_range(0, 99);
      if (roll < 80)      set_len = $urandom_range(1, 8);
      else if (roll < 95) set_len = $urandom_range(9, 24);
      else                set_len = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 6);
      roll = $urandom_range(0, 9);
      send_set(set_len, (roll < 6) ? 0 : (roll < 9) ? 1 : 2);
      if ($urandom_range(0, 9) == 0) hold_until_drained();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d distances loaded in %0d runs, %0d sorted results checked",
             items_sent, runs_done, results_seen);
    $display("tb: %0d runs overflowed the store, %0d mismatches", runs_dropped, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
